### hdl/gwch_pkg.sv
// ----------------------------------------------------------------------------
// Gift wrapping convex hull: shared types and constants
// Item layouts, status codes and the controller/datapath command and status
// groups.
// ----------------------------------------------------------------------------
`default_nettype none

package gwch_pkg;

   localparam int FIELD_BITS      = 16;
   localparam int MIN_HULL_POINTS = 3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] point_x;
      logic signed [FIELD_BITS-1:0] point_y;
      logic                         last_point;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] hull_x;
      logic signed [FIELD_BITS-1:0] hull_y;
      logic                         last_hull_point;
      logic [1:0]                   hull_status;
   } rsp_type;

   typedef struct packed {
      logic load;        // store the accepted point
      logic too_few;     // emit the too_few item and clear the set
      logic walk_init;   // start the walk at the leftmost point
      logic push;        // record current point, fetch first candidate
      logic cand_load;   // latch candidate, start the scan at point 0
      logic cmp;         // resolve one scan step
      logic advance;     // current <= candidate
      logic set_trunc;   // walk hit capacity
      logic emit_first;  // start reading the hull list
      logic emit_out;    // send one hull item
      logic finish;      // clear the set after the last item
   } cmd_type;

   typedef struct packed {
      logic n_small;
      logic scan_last;
      logic cand_is_left;
      logic hull_full;
      logic emit_last;
   } sts_type;

endpackage

`default_nettype wire

### hdl/gwch_datapath.sv
// ----------------------------------------------------------------------------
// Gift wrapping convex hull: datapath
// Point store, hull list, cross product pipe, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gwch_datapath
   import gwch_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = IDX_W + 1;
   localparam int CW    = COORD_BITS;
   localparam int DW    = CW + 1;
   localparam int PW    = 2 * DW;

   logic [2*CW-1:0] pt_mem   [MAX_POINTS];
   logic [2*CW-1:0] hull_mem [MAX_POINTS];
   logic [2*CW-1:0] pt_rd_ff;
   logic [2*CW-1:0] hull_rd_ff;
   logic [IDX_W-1:0] pt_raddr;
   logic [IDX_W-1:0] hull_raddr;

   logic signed [CW-1:0] in_x, in_y, rd_x, rd_y, hx, hy;
   logic [FIELD_BITS-1:0] out_x, out_y;

   // control registers
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] hull_cnt_ff, hull_cnt_in;
   logic             trunc_ff, trunc_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [IDX_W-1:0]     left_idx_ff, left_idx_in;
   logic signed [CW-1:0] left_x_ff, left_x_in, left_y_ff, left_y_in;
   logic [IDX_W-1:0]     cur_idx_ff, cur_idx_in;
   logic signed [CW-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [IDX_W-1:0]     cand_idx_ff, cand_idx_in;
   logic signed [CW-1:0] cand_x_ff, cand_x_in, cand_y_ff, cand_y_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     pi_idx_ff, pi_idx_in;
   logic signed [CW-1:0] pi_x_ff, pi_x_in, pi_y_ff, pi_y_in;
   logic signed [PW-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic [IDX_W-1:0]     emit_ff, emit_in;
   rsp_type              rsp_ff, rsp_in;

   logic signed [DW-1:0] dy_ip, dx_ci, dx_ip, dy_ci;
   logic [CNT_W-1:0]     cur_plus;
   logic [IDX_W-1:0]     next_idx;
   logic                 store_ok;

   generate
      if (CW <= FIELD_BITS) begin : g_in_narrow
         assign in_x = req_data.point_x[CW-1:0];
         assign in_y = req_data.point_y[CW-1:0];
      end else begin : g_in_wide
         assign in_x = {{(CW-FIELD_BITS){1'b0}}, req_data.point_x};
         assign in_y = {{(CW-FIELD_BITS){1'b0}}, req_data.point_y};
      end
      if (CW < FIELD_BITS) begin : g_out_narrow
         assign out_x = {{(FIELD_BITS-CW){1'b0}}, hx};
         assign out_y = {{(FIELD_BITS-CW){1'b0}}, hy};
      end else begin : g_out_wide
         assign out_x = hx[FIELD_BITS-1:0];
         assign out_y = hy[FIELD_BITS-1:0];
      end
   endgenerate

   assign rd_x = pt_rd_ff[2*CW-1:CW];
   assign rd_y = pt_rd_ff[CW-1:0];
   assign hx   = hull_rd_ff[2*CW-1:CW];
   assign hy   = hull_rd_ff[CW-1:0];

   assign store_ok = count_ff < CNT_W'(MAX_POINTS);
   assign cur_plus = {1'b0, cur_idx_ff} + CNT_W'(1);
   assign next_idx = (cur_plus == count_ff) ? '0 : cur_plus[IDX_W-1:0];

   // point i vs current p and candidate q
   assign dy_ip = {rd_y[CW-1], rd_y} - {cur_y_ff[CW-1], cur_y_ff};
   assign dx_ci = {cand_x_ff[CW-1], cand_x_ff} - {rd_x[CW-1], rd_x};
   assign dx_ip = {rd_x[CW-1], rd_x} - {cur_x_ff[CW-1], cur_x_ff};
   assign dy_ci = {cand_y_ff[CW-1], cand_y_ff} - {rd_y[CW-1], rd_y};

   always_comb begin
      if (cmd.push) begin
         pt_raddr = next_idx;
      end else if (cmd.cand_load) begin
         pt_raddr = '0;
      end else if (cmd.cmp) begin
         pt_raddr = scan_ff + IDX_W'(1);
      end else begin
         pt_raddr = scan_ff;
      end
      hull_raddr = cmd.emit_first ? '0 : (emit_ff + IDX_W'(1));
   end

   always_ff @(posedge clock) begin
      if (cmd.load && store_ok) begin
         pt_mem[count_ff[IDX_W-1:0]] <= {in_x, in_y};
      end
      pt_rd_ff <= pt_mem[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         hull_mem[hull_cnt_ff[IDX_W-1:0]] <= {cur_x_ff, cur_y_ff};
      end
      hull_rd_ff <= hull_mem[hull_raddr];
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      hull_cnt_in  = hull_cnt_ff;
      trunc_in     = trunc_ff;
      rsp_valid_in = 1'b0;
      left_idx_in  = left_idx_ff;
      left_x_in    = left_x_ff;
      left_y_in    = left_y_ff;
      cur_idx_in   = cur_idx_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cand_idx_in  = cand_idx_ff;
      cand_x_in    = cand_x_ff;
      cand_y_in    = cand_y_ff;
      scan_in      = scan_ff;
      pi_idx_in    = scan_ff;
      pi_x_in      = rd_x;
      pi_y_in      = rd_y;
      prod_a_in    = dy_ip * dx_ci;
      prod_b_in    = dx_ip * dy_ci;
      emit_in      = emit_ff;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         if (store_ok) begin
            count_in = count_ff + CNT_W'(1);
            if (count_ff == '0 || in_x < left_x_ff) begin
               left_idx_in = count_ff[IDX_W-1:0];
               left_x_in   = in_x;
               left_y_in   = in_y;
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.walk_init) begin
         cur_idx_in  = left_idx_ff;
         cur_x_in    = left_x_ff;
         cur_y_in    = left_y_ff;
         hull_cnt_in = '0;
         trunc_in    = 1'b0;
      end
      if (cmd.push) begin
         hull_cnt_in = hull_cnt_ff + CNT_W'(1);
         cand_idx_in = next_idx;
      end
      if (cmd.cand_load) begin
         cand_x_in = rd_x;
         cand_y_in = rd_y;
         scan_in   = '0;
      end
      if (cmd.cmp) begin
         scan_in = scan_ff + IDX_W'(1);
         if (prod_a_ff < prod_b_ff) begin
            cand_idx_in = pi_idx_ff;
            cand_x_in   = pi_x_ff;
            cand_y_in   = pi_y_ff;
         end
      end
      if (cmd.advance) begin
         cur_idx_in = cand_idx_ff;
         cur_x_in   = cand_x_ff;
         cur_y_in   = cand_y_ff;
      end
      if (cmd.set_trunc) begin
         trunc_in = 1'b1;
      end
      if (cmd.emit_first) begin
         emit_in = '0;
      end
      if (cmd.emit_out) begin
         emit_in                = emit_ff + IDX_W'(1);
         rsp_valid_in           = 1'b1;
         rsp_in.hull_x          = out_x;
         rsp_in.hull_y          = out_y;
         rsp_in.last_hull_point = sts.emit_last;
         rsp_in.hull_status     = (ovf_ff || trunc_ff) ? STATUS_OVERFLOW : STATUS_OK;
      end
      if (cmd.too_few) begin
         rsp_valid_in           = 1'b1;
         rsp_in.hull_x          = '0;
         rsp_in.hull_y          = '0;
         rsp_in.last_hull_point = 1'b1;
         rsp_in.hull_status     = STATUS_TOO_FEW;
      end
      if (cmd.too_few || cmd.finish) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         hull_cnt_ff  <= '0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         hull_cnt_ff  <= hull_cnt_in;
         trunc_ff     <= trunc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_idx_ff <= left_idx_in;
      left_x_ff   <= left_x_in;
      left_y_ff   <= left_y_in;
      cur_idx_ff  <= cur_idx_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cand_idx_ff <= cand_idx_in;
      cand_x_ff   <= cand_x_in;
      cand_y_ff   <= cand_y_in;
      scan_ff     <= scan_in;
      pi_idx_ff   <= pi_idx_in;
      pi_x_ff     <= pi_x_in;
      pi_y_ff     <= pi_y_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      emit_ff     <= emit_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      sts.n_small      = count_ff < CNT_W'(MIN_HULL_POINTS);
      sts.scan_last    = ({1'b0, scan_ff} + CNT_W'(1)) == count_ff;
      sts.cand_is_left = cand_idx_ff == left_idx_ff;
      sts.hull_full    = hull_cnt_ff == CNT_W'(MAX_POINTS);
      sts.emit_last    = ({1'b0, emit_ff} + CNT_W'(1)) == hull_cnt_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_from_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.emit_out || cmd.too_few))
      else $error("result item without an emit command");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS) && hull_cnt_ff <= CNT_W'(MAX_POINTS))
      else $error("point or hull count beyond capacity");

   a_too_few_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.hull_status == STATUS_TOO_FEW |->
         rsp_ff.last_hull_point && rsp_ff.hull_x == '0 && rsp_ff.hull_y == '0)
      else $error("too_few item malformed");

   a_clear_after_set: assert property (@(posedge clock) disable iff (reset)
      cmd.finish || cmd.too_few |=> count_ff == '0 && !ovf_ff)
      else $error("point set not cleared after last item");

endmodule

`default_nettype wire

### hdl/gwch_ctrl.sv
// ----------------------------------------------------------------------------
// Gift wrapping convex hull: controller
// Sequences loading, the hull walk scan and the emission of hull items.
// ----------------------------------------------------------------------------
`default_nettype none

module gwch_ctrl
   import gwch_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    last_point,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_START = 4'd1;
   localparam logic [3:0] ST_PUSH  = 4'd2;
   localparam logic [3:0] ST_CAND  = 4'd3;
   localparam logic [3:0] ST_MUL   = 4'd4;
   localparam logic [3:0] ST_CMP   = 4'd5;
   localparam logic [3:0] ST_NEXT  = 4'd6;
   localparam logic [3:0] ST_EMIT0 = 4'd7;
   localparam logic [3:0] ST_EMIT  = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (last_point) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (sts.n_small) begin
               cmd.too_few = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_CAND;
         end
         ST_CAND: begin
            cmd.cand_load = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = sts.scan_last ? ST_NEXT : ST_MUL;
         end
         ST_NEXT: begin
            cmd.advance = 1'b1;
            if (sts.cand_is_left) begin
               state_in = ST_EMIT0;
            end else if (sts.hull_full) begin
               cmd.set_trunc = 1'b1;
               state_in      = ST_EMIT0;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_EMIT0: begin
            cmd.emit_first = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_out = 1'b1;
            if (sts.emit_last) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

`default_nettype wire

### hdl/gift_wrapping_convex_hull_unit.sv
// ----------------------------------------------------------------------------
// Gift wrapping convex hull unit
// Loads points one item per cycle; the item flagged last_point starts a
// Jarvis march from the leftmost point and the hull is sent in walk order.
// Walk: after the last point, one cross product step (states MUL and CMP) per
//   point for each hull vertex, then the hull items, one item per cycle.
// Fewer than 3 points: the START state issues the too_few item, registered like any result.
// Throughput: one point per cycle while loading; busy stays high from the
//   last point until its final item is issued. Results cannot be stalled.
// Reset is synchronous and clears control state; the point store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module gift_wrapping_convex_hull_unit
   import gwch_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   cmd_type cmd;
   sts_type sts;

   gwch_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_point (req_data.last_point),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   gwch_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
